// ----- rtl/khl_pkg.sv -----
package khl_pkg;

    // Keyword table geometry.
    localparam int TABLE_SLOTS = 256;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W     = 9;
    localparam int HASH_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CHAR_W      = 8;
    localparam int OUT_SLOT_W  = 8;

    localparam logic [CFG_W-1:0] MULT_RESET = 16'd1024;
    localparam logic [CFG_W-1:0] DIV_RESET  = 16'd64;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_DIV  = 1'd1;

    // Iterative divider: one quotient bit per cycle.
    localparam int DIV_STEPS = HASH_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic                 func;
        logic [CHAR_W-1:0]    char_byte;
        logic                 last_char;
        logic [7:0]           table_slot;
        logic [ENTRY_W-1:0]   table_value;
    } t_in_req;

    typedef struct packed {
        logic                  is_keyword;
        logic [7:0]            sym_id;
        logic [OUT_SLOT_W-1:0] hash_slot;
    } t_out_rsp;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        ALU_NONE = 3'd0,
        ALU_ADDC = 3'd1,
        ALU_MUL  = 3'd2,
        ALU_ADDP = 3'd3,
        ALU_XORQ = 3'd4,
        ALU_FIN1 = 3'd5,
        ALU_FIN2 = 3'd6,
        ALU_FIN3 = 3'd7
    } t_alu_op;

    // Jump conditions: the jump is taken when the condition is true.
    typedef enum logic [2:0] {
        COND_NONE    = 3'd0,
        COND_ALWAYS  = 3'd1,
        COND_NOREQ   = 3'd2,
        COND_FUNC    = 3'd3,
        COND_DIVBUSY = 3'd4,
        COND_OUTFULL = 3'd5
    } t_cond;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] ST_DISP  = 4'd1;
    localparam logic [STEP_W-1:0] ST_ADDC  = 4'd2;
    localparam logic [STEP_W-1:0] ST_MUL   = 4'd3;
    localparam logic [STEP_W-1:0] ST_ADDP  = 4'd4;
    localparam logic [STEP_W-1:0] ST_DIVS  = 4'd5;
    localparam logic [STEP_W-1:0] ST_DIVW  = 4'd6;
    localparam logic [STEP_W-1:0] ST_XORQ  = 4'd7;
    localparam logic [STEP_W-1:0] ST_SAVE  = 4'd8;
    localparam logic [STEP_W-1:0] ST_FIN1  = 4'd9;
    localparam logic [STEP_W-1:0] ST_FIN2  = 4'd10;
    localparam logic [STEP_W-1:0] ST_FIN3  = 4'd11;
    localparam logic [STEP_W-1:0] ST_READ  = 4'd12;
    localparam logic [STEP_W-1:0] ST_OUT   = 4'd13;
    localparam logic [STEP_W-1:0] ST_RET   = 4'd14;
    localparam logic [STEP_W-1:0] ST_WRITE = 4'd15;

    typedef struct packed {
        t_alu_op           alu;
        logic              ld_req;
        logic              div_start;
        logic              hash_save;
        logic              ram_rd;
        logic              ram_wr;
        logic              out_load;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uop;

    // Status seen by the sequencer's jump logic.
    typedef struct packed {
        logic in_valid;
        logic func;
        logic div_busy;
        logic out_full;
    } t_seq_cond;

    localparam t_uop UOP_NOP = '{
        alu: ALU_NONE, ld_req: 1'b0, div_start: 1'b0, hash_save: 1'b0,
        ram_rd: 1'b0, ram_wr: 1'b0, out_load: 1'b0, cond: COND_NONE,
        target: ST_IDLE
    };

    // Control store of the sequencer.
    function automatic t_uop ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = UOP_NOP;
        case (step)
            ST_IDLE: begin
                u.ld_req = 1'b1;
                u.cond   = COND_NOREQ;
                u.target = ST_IDLE;
            end
            ST_DISP: begin
                u.cond   = COND_FUNC;
                u.target = ST_WRITE;
            end
            ST_ADDC: u.alu = ALU_ADDC;
            ST_MUL:  u.alu = ALU_MUL;
            ST_ADDP: u.alu = ALU_ADDP;
            ST_DIVS: u.div_start = 1'b1;
            ST_DIVW: begin
                u.cond   = COND_DIVBUSY;
                u.target = ST_DIVW;
            end
            ST_XORQ: u.alu = ALU_XORQ;
            ST_SAVE: begin
                u.hash_save = 1'b1;
                u.cond      = COND_FUNC;
                u.target    = ST_IDLE;
            end
            ST_FIN1: u.alu = ALU_FIN1;
            ST_FIN2: u.alu = ALU_FIN2;
            ST_FIN3: u.alu = ALU_FIN3;
            ST_READ: u.ram_rd = 1'b1;
            ST_OUT: begin
                u.out_load = 1'b1;
                u.cond     = COND_OUTFULL;
                u.target   = ST_OUT;
            end
            ST_RET: begin
                u.cond   = COND_ALWAYS;
                u.target = ST_IDLE;
            end
            ST_WRITE: begin
                u.ram_wr = 1'b1;
                u.cond   = COND_ALWAYS;
                u.target = ST_IDLE;
            end
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/khl_ram.sv -----
module khl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/khl_div.sv -----
module khl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [khl_pkg::HASH_W-1:0]  i_num,
    input  logic [khl_pkg::CFG_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [khl_pkg::HASH_W-1:0]  o_quo
);

    import khl_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CFG_W-1:0]     r_rem;
    logic [CFG_W-1:0]     r_den;
    logic [HASH_W-1:0]    r_quo;
    logic [CFG_W:0]       shifted;
    logic [CFG_W:0]       diff;
    logic                 ge;

    // Restoring division, one quotient bit per cycle. A zero divisor
    // makes every trial subtraction succeed, so the quotient is all ones.
    always_comb begin
        shifted = {r_rem, r_quo[HASH_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[CFG_W-1:0] : shifted[CFG_W-1:0];
            r_quo <= {r_quo[HASH_W-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

// ----- rtl/khl_seq.sv -----
module khl_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  khl_pkg::t_seq_cond          i_cond,
    output khl_pkg::t_uop               o_uop,
    output logic [khl_pkg::STEP_W-1:0]  o_step
);

    import khl_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uop              uop;
    logic              take;

    always_comb begin
        uop = ucode(r_step);
        case (uop.cond)
            COND_NONE:    take = 1'b0;
            COND_ALWAYS:  take = 1'b1;
            COND_NOREQ:   take = !i_cond.in_valid;
            COND_FUNC:    take = i_cond.func;
            COND_DIVBUSY: take = i_cond.div_busy;
            COND_OUTFULL: take = i_cond.out_full;
            default:      take = 1'b0;
        endcase
        n_step = take ? uop.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uop  = uop;
    assign o_step = r_step;

endmodule

// ----- rtl/keyword_hash_lookup.sv -----
// Keyword lookup by a per-character hash of an identifier.
// Requests enter on the input channel (i_in_valid / o_in_ready), one at a
// time. A request with func low carries one identifier character; it is
// upper-cased and folded into a 32-bit running hash. A request with func
// high writes one entry of the 256-slot keyword table instead.
// A character marked last also finalizes the hash, reads the keyword table
// at the hashed slot and produces one result on the output channel
// (o_out_valid / i_out_ready); all other requests produce no result.
// A microcoded step counter orders the work. A character runs the fold steps,
// among them the 32-step radix-2 divider that the fold needs; a last one then
// runs the finalize, table read and output steps; a table write branches to
// the write step. The result sits in an output register; a stalled receiver
// only holds the sequencer once a second result is ready while the first is
// still waiting. Reset returns both configuration registers to their
// defaults, clears the running hash and marks every table entry empty
// through per-slot valid bits, so the block is usable in the first cycle
// after reset. Configuration (multiplier, divider) is written through
// i_cfg_we; the user must do so only while idle, unchecked by the block.
module keyword_hash_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  khl_pkg::t_in_req              i_in_req,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output khl_pkg::t_out_rsp             o_out_rsp,
    input  logic                          i_cfg_we,
    input  logic [khl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [khl_pkg::CFG_W-1:0]     i_cfg_wdata
);

    import khl_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] r_mult;
    logic [CFG_W-1:0] r_div;

    // Latched request and hash datapath.
    t_in_req           r_req;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_work;
    logic [HASH_W-1:0] r_prod;
    logic [HASH_W+CFG_W-1:0] mul_full;
    logic [CHAR_W-1:0] upc;

    // Table valid bits and read side.
    logic [TABLE_SLOTS-1:0] r_tab_valid;
    logic                   r_rd_valid;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [SLOT_W-1:0]      rd_addr;
    logic [SLOT_W-1:0]      wr_addr;
    logic [HASH_W-1:0]      wslot_ext;
    logic [HASH_W-1:0]      slot_ext;

    // Output register.
    logic     r_out_valid;
    t_out_rsp r_out_rsp;
    logic     out_full;
    logic     out_load;
    logic     entry_hit;

    // Sequencer and divider.
    t_uop              uop;
    t_seq_cond         cond;
    logic [STEP_W-1:0] step;
    logic              div_busy;
    logic [HASH_W-1:0] div_quo;
    logic              in_accept;

    always_comb begin
        // Only the lower-case letters fold; all other bytes pass unchanged.
        if (r_req.char_byte inside {[8'h61:8'h7A]}) begin
            upc = r_req.char_byte - 8'h20;
        end else begin
            upc = r_req.char_byte;
        end
        mul_full  = r_work * r_mult;
        wslot_ext = {{(HASH_W-8){1'b0}}, r_req.table_slot};
        wr_addr   = wslot_ext[SLOT_W-1:0];
        rd_addr   = r_work[SLOT_W-1:0];
        slot_ext  = r_work & HASH_W'(TABLE_SLOTS - 1);
        // An entry never written reads as empty; bit 8 set also means empty.
        entry_hit = r_rd_valid && !ram_rdata[ENTRY_W-1];
    end

    assign out_full  = r_out_valid && !i_out_ready;
    assign out_load  = uop.out_load && !out_full;
    assign in_accept = i_in_valid && o_in_ready;

    assign cond.in_valid = i_in_valid;
    assign cond.func     = (step == ST_SAVE) ? !r_req.last_char : r_req.func;
    assign cond.div_busy = div_busy;
    assign cond.out_full = out_full;

    khl_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_uop   (uop),
        .o_step  (step)
    );

    khl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (uop.div_start),
        .i_num   (r_work),
        .i_den   (r_div),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    khl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (uop.ram_wr),
        .i_waddr (wr_addr),
        .i_wdata (r_req.table_value),
        .i_re    (uop.ram_rd),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= MULT_RESET;
            r_div  <= DIV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HASH_MULT: r_mult <= i_cfg_wdata;
                CFG_HASH_DIV:  r_div  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Running hash: kept between characters, cleared after a last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else if (uop.hash_save) begin
            r_hash <= r_req.last_char ? '0 : r_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_req;
        end
        case (uop.alu)
            ALU_ADDC: r_work <= r_hash + {{(HASH_W-CHAR_W){1'b0}}, upc};
            ALU_MUL:  r_prod <= mul_full[HASH_W-1:0];
            ALU_ADDP: r_work <= r_work + r_prod;
            ALU_XORQ: r_work <= r_work ^ div_quo;
            ALU_FIN1: r_work <= r_work + {r_work[HASH_W-4:0], 3'b000};
            ALU_FIN2: r_work <= r_work ^ {11'd0, r_work[HASH_W-1:11]};
            ALU_FIN3: r_work <= r_work + {r_work[HASH_W-6:0], 5'b00000};
            default: begin
            end
        endcase
        if (uop.ram_rd) begin
            r_rd_valid <= r_tab_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
        end else if (uop.ram_wr) begin
            r_tab_valid[wr_addr] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rsp.is_keyword <= entry_hit;
            r_out_rsp.sym_id     <= entry_hit ? ram_rdata[7:0] : 8'd0;
            r_out_rsp.hash_slot  <= slot_ext[OUT_SLOT_W-1:0];
        end
    end

    assign o_in_ready  = uop.ld_req;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // The divider is only started once the previous division has finished.
    a_div_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        uop.div_start |-> !div_busy)
        else $error("divider started while busy");

    // One request at a time: the block is not ready right after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    // A new result only follows a last character, after the hash was cleared.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_req.func && r_req.last_char && r_hash == '0))
        else $error("result produced without a finished identifier");

    // A waiting result is never replaced before the receiver takes it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !out_load)
        else $error("pending result overwritten");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import khl_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 7;
    // A plain character keeps the block busy while producing nothing, so after
    // the last result the block may still be folding a trailing character.
    localparam int SETTLE_CYCLES  = 60;
    // Long receiver hold-off: covers several identifiers, so the output
    // register fills and the sequencer backs up into the request channel.
    localparam int RX_HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int NUM_PHASES     = 4;
    localparam int PHASE_REQS     = 275;

    localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = ENTRY_W'(256);

    // One row of the directed table: either a request or a register update.
    typedef enum logic {
        ROW_REQ = 1'b0,
        ROW_CFG = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_in_req           req;
        logic [CFG_W-1:0]  cfg_mult;
        logic [CFG_W-1:0]  cfg_div;
        logic              typed;
        t_out_rsp          rsp;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_req               i_in_req    = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_HASH_MULT;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_rsp              o_out_rsp;

    // Shadow of the block's state: running hash, keyword table and both
    // registers, advanced once per accepted request.
    logic [HASH_W-1:0]     model_hash = '0;
    logic [CFG_W-1:0]      model_mult = MULT_RESET;
    logic [CFG_W-1:0]      model_div  = DIV_RESET;
    logic [ENTRY_W-1:0]    model_table [TABLE_SLOTS];

    // Lookup results still owed by the block, oldest first.
    t_out_rsp              pending_lookups[$];

    int unsigned           err_cnt      = 0;
    int unsigned           tx_idle_pct  = 0;
    int unsigned           rx_stall_pct = 0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int unsigned           hold_asked   = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    keyword_hash_lookup u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // One character step of the hash. Only 'a'..'z' are upper-cased; the
    // product wraps at 32 bits, and a zero divider yields an all-ones
    // quotient, which simply inverts the hash.
    function automatic logic [HASH_W-1:0] fold_char(input logic [HASH_W-1:0] h,
                                                    input logic [CHAR_W-1:0] ch,
                                                    input logic [CFG_W-1:0]  mult,
                                                    input logic [CFG_W-1:0]  div);
        logic [HASH_W-1:0] c;
        logic [HASH_W-1:0] quot;
        c = HASH_W'(ch);
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            c = c - 32'h20;
        end
        h = h + c;
        h = h + h * HASH_W'(mult);
        quot = (div == '0) ? '1 : h / HASH_W'(div);
        return h ^ quot;
    endfunction

    // Final avalanche applied on the last character of an identifier.
    function automatic logic [HASH_W-1:0] finalize_hash(input logic [HASH_W-1:0] h);
        h = h + h * 32'd8;
        h = h ^ (h / 32'd2048);
        h = h + h * 32'd32;
        return h;
    endfunction

    // Advances the shadow state by one accepted request and returns the
    // lookup result, if the request produces one.
    task automatic predict_lookup(input t_in_req req, output logic has_rsp,
                                  output t_out_rsp rsp);
        logic [HASH_W-1:0]  h;
        logic [ENTRY_W-1:0] entry;
        int                 slot;
        has_rsp = 1'b0;
        rsp     = '0;
        if (req.func) begin
            model_table[int'(req.table_slot) & (TABLE_SLOTS - 1)] = req.table_value;
        end else begin
            h = fold_char(model_hash, req.char_byte, model_mult, model_div);
            if (!req.last_char) begin
                model_hash = h;
            end else begin
                model_hash = '0;
                h = finalize_hash(h);
                slot  = int'(h[SLOT_W-1:0]);
                entry = model_table[slot];
                has_rsp        = 1'b1;
                // Bit 8 set means empty, whatever the low bits hold.
                rsp.is_keyword = !entry[ENTRY_W-1];
                rsp.sym_id     = entry[ENTRY_W-1] ? 8'd0 : entry[7:0];
                rsp.hash_slot  = OUT_SLOT_W'(slot);
            end
        end
    endtask

    function automatic t_in_req make_req(input logic func, input logic [CHAR_W-1:0] ch,
                                         input logic last);
        t_in_req r;
        // Fields that this kind of request ignores still get random values.
        r.func        = func;
        r.char_byte   = ch;
        r.last_char   = last;
        r.table_slot  = 8'($urandom);
        r.table_value = ENTRY_W'($urandom);
        return r;
    endfunction

    function automatic t_in_req table_write(input logic [7:0] slot,
                                            input logic [ENTRY_W-1:0] value);
        t_in_req r;
        r = make_req(1'b1, CHAR_W'($urandom), 1'($urandom));
        r.table_slot  = slot;
        r.table_value = value;
        return r;
    endfunction

    // Identifier characters lean toward letters of both cases and digits.
    function automatic logic [CHAR_W-1:0] random_char();
        case ($urandom_range(4))
            0, 1:    return 8'h61 + 8'($urandom_range(25));
            2:       return 8'h41 + 8'($urandom_range(25));
            3:       return 8'h30 + 8'($urandom_range(9));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_row row_char(input logic [CHAR_W-1:0] ch, input logic last);
        t_row r;
        r      = '0;
        r.kind = ROW_REQ;
        r.req  = make_req(1'b0, ch, last);
        return r;
    endfunction

    // A lone NUL character hashes to slot 0 while the running hash is clear
    // and the divider is nonzero, so its result can be written down directly.
    function automatic t_row row_hit(input logic kw, input logic [7:0] sym,
                                     input logic [OUT_SLOT_W-1:0] slot);
        t_row r;
        r                = row_char(8'h00, 1'b1);
        r.typed          = 1'b1;
        r.rsp.is_keyword = kw;
        r.rsp.sym_id     = sym;
        r.rsp.hash_slot  = slot;
        return r;
    endfunction

    function automatic t_row row_write(input logic [7:0] slot,
                                       input logic [ENTRY_W-1:0] value);
        t_row r;
        r      = '0;
        r.kind = ROW_REQ;
        r.req  = table_write(slot, value);
        return r;
    endfunction

    function automatic t_row row_cfg(input logic [CFG_W-1:0] mult,
                                     input logic [CFG_W-1:0] div);
        t_row r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.cfg_mult = mult;
        r.cfg_div  = div;
        return r;
    endfunction

    // Offers one request, holding valid and payload steady until the block
    // takes it, then records what that request should produce.
    task automatic send_request(input t_in_req req, input logic typed,
                                input t_out_rsp typed_rsp);
        logic     has_rsp;
        t_out_rsp rsp;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_lookup(req, has_rsp, rsp);
        if (has_rsp) begin
            pending_lookups.push_back(typed ? typed_rsp : rsp);
        end
    endtask

    // Waits until every result is in, then lets a trailing character or
    // table write finish before the registers may be touched.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers on consecutive cycles.
    task automatic load_config(input logic [CFG_W-1:0] mult, input logic [CFG_W-1:0] div);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_HASH_MULT;
        i_cfg_wdata <= mult;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_HASH_DIV;
        i_cfg_wdata <= div;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_mult = mult;
        model_div  = div;
    endtask

    task automatic check_lookup(input t_out_rsp got);
        t_out_rsp want;
        if (pending_lookups.size() == 0) begin
            $error("result with no lookup pending: is_keyword=%0d sym_id=%0d hash_slot=%0d",
                   got.is_keyword, got.sym_id, got.hash_slot);
            err_cnt++;
            return;
        end
        want = pending_lookups.pop_front();
        if (got.is_keyword !== want.is_keyword) begin
            $error("is_keyword: expected %0d, got %0d", want.is_keyword, got.is_keyword);
            err_cnt++;
        end
        if (got.sym_id !== want.sym_id) begin
            $error("sym_id: expected %0d, got %0d", want.sym_id, got.sym_id);
            err_cnt++;
        end
        if (got.hash_slot !== want.hash_slot) begin
            $error("hash_slot: expected %0d, got %0d", want.hash_slot, got.hash_slot);
            err_cnt++;
        end
    endtask

    // Receiver: samples the result channel at each rising edge, then picks
    // the next ready value. A requested hold-off is counted down here, apart
    // from the stimulus, which keeps offering requests meanwhile.
    initial begin : receiver
        int unsigned hold_done;
        int unsigned hold_left;
        hold_done = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_lookup(o_out_rsp);
            end
            if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("FAIL keyword_hash_lookup");
        $finish;
    end

    initial begin : stimulus
        t_row directed_rows[$];
        int   sent;
        int   id_len;
        foreach (model_table[i]) model_table[i] = EMPTY_ENTRY;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run back to back at reset settings until the table
        // changes them. The typed rows use the NUL identifier on slot 0.
        directed_rows = '{
            row_hit(1'b0, 8'd0, 8'd0),          // fresh table: every slot empty
            row_char(8'h61, 1'b0),              // lower-case edges fold to upper
            row_char(8'h7A, 1'b0),
            row_char(8'h60, 1'b0),              // neighbors of the range do not
            row_char(8'h7B, 1'b1),
            row_char(8'h41, 1'b0),
            row_char(8'h5A, 1'b1),
            row_char(8'h80, 1'b0),              // high bytes stay unsigned
            row_char(8'hFF, 1'b1),
            row_write(8'd0, 9'd0),              // symbol id zero is still a keyword
            row_hit(1'b1, 8'd0, 8'd0),
            row_write(8'd0, 9'd255),
            row_hit(1'b1, 8'd255, 8'd0),
            row_write(8'd0, 9'd511),            // bit 8 set reads as empty
            row_hit(1'b0, 8'd0, 8'd0),
            row_write(8'd255, 9'd256),
            row_write(8'd0, 9'd170),
            row_cfg(16'h0000, 16'hFFFF),
            row_char(8'hFF, 1'b1),
            row_cfg(16'hFFFF, 16'h0000),        // zero divider inverts the hash
            row_char(8'h00, 1'b1),
            row_char(8'h7A, 1'b0),
            row_char(8'hFF, 1'b1),
            row_cfg(MULT_RESET, 16'h0001),
            row_char(8'h5A, 1'b1)
        };
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_drained();
                load_config(directed_rows[i].cfg_mult, directed_rows[i].cfg_div);
            end else begin
                send_request(directed_rows[i].req, directed_rows[i].typed,
                             directed_rows[i].rsp);
            end
        end

        // Random part: whole identifiers of random length, with table writes
        // mixed in so that lookups increasingly land on filled slots. Each
        // phase has its own register setting and idling pattern.
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    load_config(CFG_W'($urandom), CFG_W'($urandom_range(65535, 1)));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                    // Full-rate requests against a receiver that stops for a
                    // long while: the block must back-pressure the sender.
                    hold_asked++;
                end
                1: begin
                    load_config(16'hFFFF, 16'hFFFF);
                    tx_idle_pct  = 70;
                    rx_stall_pct = 0;
                end
                2: begin
                    load_config(16'h0000, CFG_W'($urandom_range(65535, 1)));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 70;
                end
                default: begin
                    load_config(CFG_W'($urandom), 16'h0000);
                    tx_idle_pct  = 12;
                    rx_stall_pct = 12;
                end
            endcase
            sent = 0;
            while (sent < PHASE_REQS) begin
                id_len = $urandom_range(8, 1);
                for (int k = 0; k < id_len; k++) begin
                    if ($urandom_range(99) < 20) begin
                        send_request(table_write(8'($urandom),
                                                 ($urandom_range(99) < 70) ?
                                                 ENTRY_W'($urandom_range(255)) :
                                                 ENTRY_W'($urandom_range(511, 256))),
                                     1'b0, '0);
                        sent++;
                    end
                    send_request(make_req(1'b0, random_char(), k == id_len - 1), 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_drained();
        if (err_cnt == 0) begin
            $display("PASS keyword_hash_lookup");
        end else begin
            $display("FAIL keyword_hash_lookup");
        end
        $finish;
    end

endmodule
